// ===== rtl/core/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// Shared types, constants and byte functions of the AES-128 encryption core.
// ----------------------------------------------------------------------------
package aes_pkg;

  // One plaintext word in.
  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } aes_in_t;

  // One ciphertext word out.
  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } aes_out_t;

  // Configuration register indexes.
  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  localparam int unsigned NumRounds = 10;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    begin
      case (a)
        8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
        8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
        8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
        8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
        8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
        8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
        8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
        8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
        8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
        8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
        8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
        8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
        8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
        8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
        8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
        8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
        8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
        8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
        8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
        8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
        8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
        8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
        8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
        8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
        8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
        8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
        8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
        8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
        8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
        8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
        8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
        8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
        8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
        8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
        8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
        8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
        8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
        8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
        8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
        8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
        8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
        8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
        8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
        8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
        8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
        8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
        8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
        8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
        8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
        8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
        8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
        8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
        8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
        8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
        8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
        8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
        8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
        8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
        8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
        8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
        8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
        8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
        8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
        8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

  // Round constant for rounds 1 to 10.
  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    begin
      case (rnd)
        4'd1: r = 8'h01;  4'd2: r = 8'h02;  4'd3: r = 8'h04;  4'd4: r = 8'h08;
        4'd5: r = 8'h10;  4'd6: r = 8'h20;  4'd7: r = 8'h40;  4'd8: r = 8'h80;
        4'd9: r = 8'h1b;  4'd10: r = 8'h36;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
  endfunction

endpackage

// ===== rtl/core/aes_key_expand.sv =====
// ----------------------------------------------------------------------------
// AES key expansion
// Builds the eleven round keys, one round key per cycle, after a key change.
// ----------------------------------------------------------------------------
module aes_key_expand (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic [127:0]                             key_i,
  output logic                                     done_o,
  output logic [aes_pkg::NumRounds:0][127:0]       rkeys_o
);

  logic [aes_pkg::NumRounds:0][127:0] rk_q;
  logic [3:0]                         rnd_q, rnd_d;
  logic                               run_q, run_d;
  logic                               done_q, done_d;
  logic [127:0]                       prev, next;
  logic [31:0]                        t;

  // One round key from the previous one: four chained word updates.
  always_comb begin
    prev    = rk_q[rnd_q - 4'd1];
    t       = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^
              {aes_pkg::rcon(rnd_q), 24'h0};
    next[127:96] = prev[127:96] ^ t;
    next[95:64]  = prev[95:64]  ^ next[127:96];
    next[63:32]  = prev[63:32]  ^ next[95:64];
    next[31:0]   = prev[31:0]   ^ next[63:32];
  end

  // Sequencer over rounds one to ten.
  always_comb begin
    run_d  = run_q;
    rnd_d  = rnd_q;
    done_d = done_q;
    if (start_i) begin
      run_d  = 1'b1;
      rnd_d  = 4'd1;
      done_d = 1'b0;
    end else if (run_q) begin
      rnd_d = rnd_q + 4'd1;
      if (rnd_q == 4'(aes_pkg::NumRounds)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      rnd_q  <= 4'd1;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      rnd_q  <= rnd_d;
      done_q <= done_d;
    end
  end

  // Round key store.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rk_q[0] <= key_i;
    end else if (run_q) begin
      rk_q[rnd_q] <= next;
    end
  end

  assign done_o  = done_q;
  assign rkeys_o = rk_q;

  // The sequencer never runs and reports done together.
  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(run_q && done_q)) else $error("expansion running while done");
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> run_q && rnd_q == 4'd1) else $error("expansion did not start");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(run_q)) else $error("done without a run");

endmodule

// ===== rtl/core/aes_round.sv =====
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher round; the final round skips MixColumns.
// ----------------------------------------------------------------------------
module aes_round #(
  parameter bit Final = 1'b0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  output logic         valid_o,
  output logic [127:0] state_o
);

  logic [7:0]   b [16];
  logic [7:0]   s [16];
  logic [7:0]   m [16];
  logic [127:0] mixed;
  logic [127:0] state_d, state_q;
  logic         valid_q;

  // SubBytes with ShiftRows, then MixColumns per column (skipped in the final round) and AddRoundKey.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      b[i] = state_i[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        s[4*c + r] = aes_pkg::sbox(b[4*((c + r) % 4) + r]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all;
      all = s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
      m[4*c]   = s[4*c]   ^ all ^ aes_pkg::xtime(s[4*c]   ^ s[4*c+1]);
      m[4*c+1] = s[4*c+1] ^ all ^ aes_pkg::xtime(s[4*c+1] ^ s[4*c+2]);
      m[4*c+2] = s[4*c+2] ^ all ^ aes_pkg::xtime(s[4*c+2] ^ s[4*c+3]);
      m[4*c+3] = s[4*c+3] ^ all ^ aes_pkg::xtime(s[4*c+3] ^ s[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      mixed[127 - 8*i -: 8] = Final ? s[i] : m[i];
    end
    state_d = mixed ^ rkey_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

// ===== rtl/core/aes128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Pipelined AES-128 cipher: key expansion plus eleven registered stages.
// ----------------------------------------------------------------------------
// The done strobe follows start through the initial AddRoundKey stage and the
// ten round stages, each one register.
// Throughput: one word per cycle while busy is low; busy is high while a key
// write is pending and while the key expands after a key write or after reset.
// Reset clears the key to zero and empties the pipeline.
module aes128_block_encrypt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [63:0]       cfg_data_i,
  input  logic              start,
  output logic              busy,
  input  aes_pkg::aes_in_t  data_i,
  output logic              done,
  output aes_pkg::aes_out_t data_o
);

  logic [63:0]  key_hi_q, key_lo_q;
  logic         need_q, need_d;
  logic         kx_start;
  logic         kx_done;
  logic [aes_pkg::NumRounds:0][127:0] rkeys;
  logic         accept;
  logic         v0_q;
  logic [127:0] st0_q;
  logic [aes_pkg::NumRounds:0]        v;
  logic [aes_pkg::NumRounds:0][127:0] st;

  // Key registers; any write asks for a fresh expansion.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      need_q   <= 1'b1;
    end else begin
      need_q <= need_d;
      if (cfg_we_i && cfg_idx_i == aes_pkg::RegKeyHigh) begin
        key_hi_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == aes_pkg::RegKeyLow) begin
        key_lo_q <= cfg_data_i;
      end
    end
  end

  assign kx_start = need_q && !cfg_we_i;
  assign need_d   = cfg_we_i ? 1'b1 : 1'b0;

  aes_key_expand u_kx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kx_start),
    .key_i   ({key_hi_q, key_lo_q}),
    .done_o  (kx_done),
    .rkeys_o (rkeys)
  );

  assign busy   = !kx_done || need_q;
  assign accept = start && !busy;

  // Initial AddRoundKey stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    st0_q <= {data_i.plain_high, data_i.plain_low} ^ rkeys[0];
  end

  assign v[0]  = v0_q;
  assign st[0] = st0_q;

  // Round stages.
  for (genvar g = 1; g <= aes_pkg::NumRounds; g++) begin : g_rnd
    aes_round #(.Final(g == aes_pkg::NumRounds)) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[g-1]),
      .state_i (st[g-1]),
      .rkey_i  (rkeys[g]),
      .valid_o (v[g]),
      .state_o (st[g])
    );
  end

  assign done               = v[aes_pkg::NumRounds];
  assign data_o.cipher_high = st[aes_pkg::NumRounds][127:64];
  assign data_o.cipher_low  = st[aes_pkg::NumRounds][63:0];

  // Words enter only with a finished key schedule.
  a_acc_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> kx_done) else $error("word taken before key expansion");
  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v[0]) else $error("accepted word lost");
  a_busy_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy) else $error("not busy after key write");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 encryption testbench
// Drives plaintext words into the cipher under a sequence of keys, predicts
// each ciphertext with an independent AES-128 model and checks every result.
// ----------------------------------------------------------------------------

// Scoreboard: holds the current key schedule and the ciphertexts still due.
class aes_scoreboard;
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic [31:0] sched[44];
  bit          sched_valid;
  logic [7:0]  sbox_tab[256];
  bit          sbox_built;
  aes_pkg::aes_out_t pending[$];
  int unsigned mismatches;

  function void set_key(input bit which, input logic [63:0] value);
    if (which == aes_pkg::RegKeyHigh) key_hi = value;
    else key_lo = value;
    sched_valid = 0;
  endfunction

  function logic [7:0] sb_calc(input logic [7:0] a);
    logic [7:0] inv;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] x;
    // S-box derived as GF(2^8) inverse plus affine map, not taken from a table.
    inv = 8'h00;
    if (a != 0) begin
      for (int c = 1; c < 256; c++) begin
        p = 0;
        q = a;
        x = c[7:0];
        for (int k = 0; k < 8; k++) begin
          if (x[k]) p ^= q;
          q = {q[6:0], 1'b0} ^ (q[7] ? 8'h1b : 8'h00);
        end
        if (p == 8'h01) inv = c[7:0];
      end
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
           ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  // The derived S-box is built once and then looked up.
  function logic [7:0] sb(input logic [7:0] a);
    if (!sbox_built) begin
      for (int i = 0; i < 256; i++) sbox_tab[i] = sb_calc(i[7:0]);
      sbox_built = 1;
    end
    return sbox_tab[a];
  endfunction

  function logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function void expand();
    logic [31:0] t;
    logic [7:0]  rc;
    sched[0] = key_hi[63:32];
    sched[1] = key_hi[31:0];
    sched[2] = key_lo[63:32];
    sched[3] = key_lo[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sb(t[31:24]) ^ rc, sb(t[23:16]), sb(t[15:8]), sb(t[7:0])};
        rc = dbl(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
    sched_valid = 1;
  endfunction

  // Note an accepted plaintext word and queue its ciphertext.
  function void note_plaintext(input aes_pkg::aes_in_t w);
    logic [7:0]   st[16];
    logic [7:0]   tmp[16];
    logic [127:0] blk;
    logic [7:0]   a0, a1, a2, a3, all;
    aes_pkg::aes_out_t res;
    if (!sched_valid) expand();
    blk = {w.plain_high, w.plain_low};
    for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        tmp = st;
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) st[4*c+r] = sb(tmp[4*((c+r)%4)+r]);
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
            st[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
            st[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
            st[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) st[4*c+r] ^= sched[4*rnd+c][31-8*r -: 8];
    end
    for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = st[i];
    res.cipher_high = blk[127:64];
    res.cipher_low  = blk[63:0];
    pending.push_back(res);
  endfunction

  // Check one ciphertext word against the oldest expectation.
  function void check_cipher(input aes_pkg::aes_out_t got);
    aes_pkg::aes_out_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected ciphertext %h", got);
      return;
    end
    want = pending.pop_front();
    if (got.cipher_high !== want.cipher_high || got.cipher_low !== want.cipher_low) begin
      mismatches++;
      if (mismatches <= 10) $display("ciphertext mismatch: expected %h got %h", want, got);
    end
  endfunction
endclass

module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  aes_pkg::aes_in_t  data_i = '0;
  logic        done;
  aes_pkg::aes_out_t data_o;

  aes_scoreboard board = new();

  aes128_block_encrypt dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Check every ciphertext word on its strobe.
  always @(posedge clk_i) begin
    if (rst_ni && done === 1'b1) board.check_cipher(data_o);
  end

  // Limit on the whole run.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  // One register write; the enable stays high until end_writes.
  task automatic write_key(input logic [0:0] which, input logic [63:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= which;
    cfg_data_i <= value;
    @(posedge clk_i);
    board.set_key(which, value);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_both(input logic [63:0] hi, input logic [63:0] lo);
    write_key(aes_pkg::RegKeyHigh, hi);
    write_key(aes_pkg::RegKeyLow, lo);
    end_writes();
  endtask

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input aes_pkg::aes_in_t w);
    start  <= 1'b1;
    data_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_plaintext(w);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Wait until every queued ciphertext has been seen, then let the pipe settle.
  task automatic drain();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (board.pending.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (14) @(posedge clk_i);
  endtask

  function automatic aes_pkg::aes_in_t rand_word();
    aes_pkg::aes_in_t w;
    w.plain_high = {$urandom(), $urandom()};
    w.plain_low  = {$urandom(), $urandom()};
    return w;
  endfunction

  task automatic random_phase(input int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_word(rand_word());
        left--;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 13));
    end
  endtask

  initial begin
    aes_pkg::aes_in_t w;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key (all zero) with no write yet.
    send_word('0);
    send_word('1);
    drain();
    // FIPS-197 example key and plaintext.
    set_both(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    w = {64'h0011223344556677, 64'h8899aabbccddeeff};
    send_word(w);
    send_word('0);
    send_word('1);
    send_word({64'h8000000000000000, 64'h0000000000000001});
    drain();
    set_both('1, '1);
    send_word('0);
    send_word('1);
    send_word({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
    drain();
    // Only one half rewritten: re-expansion must pick up the change.
    write_key(aes_pkg::RegKeyLow, 64'h0);
    end_writes();
    send_word('1);
    send_word({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
    drain();
    write_key(aes_pkg::RegKeyHigh, 64'h2b7e151628aed2a6);
    write_key(aes_pkg::RegKeyLow, 64'habf7158809cf4f3c);
    end_writes();
    send_word({64'h3243f6a8885a308d, 64'h313198a2e0370734});
    drain();

    // Random phases, each under a fresh random key.
    for (int ph = 0; ph < 7; ph++) begin
      set_both({$urandom(), $urandom()}, {$urandom(), $urandom()});
      random_phase(250);
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
